### rtl/motor_speed_pid_controller_core_defines.svh
// assertion macros used by the checker file
`ifndef MOTOR_SPEED_PID_CONTROLLER_CORE_DEFINES_SVH
`define MOTOR_SPEED_PID_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MSPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MSPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mspc_pkg.sv
package mspc_pkg;

	localparam int GAIN_FRAC_BITS = 8;

	localparam int GAIN_W   = 16;
	localparam int SPEED_W  = 16;
	localparam int LIMIT_W  = 15;
	localparam int DUTY_W   = 16;
	localparam int ERR_W    = 18;
	localparam int SUM_W    = 16;
	localparam int ACC_W    = 36;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	typedef enum logic [1:0] {
		OP_SAMPLE    = 2'd0,
		OP_START_FWD = 2'd1,
		OP_START_REV = 2'd2,
		OP_STOP      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_SET_DUTY = 2'd0,
		CMD_RUN_FWD  = 2'd1,
		CMD_RUN_REV  = 2'd2,
		CMD_BRAKE    = 2'd3
	} cmd_t;

	// register index, paddr[4:2]
	localparam logic [2:0] REG_GAIN_P    = 3'd0;
	localparam logic [2:0] REG_GAIN_I    = 3'd1;
	localparam logic [2:0] REG_GAIN_D    = 3'd2;
	localparam logic [2:0] REG_INT_LIMIT = 3'd3;
	localparam logic [2:0] REG_BASE_DUTY = 3'd4;

endpackage

### rtl/motor_speed_pid_controller_core.sv
// Positional PID speed loop with a clamped integral. Each command beat is a
// sample, start forward, start reverse or stop. A start loads the target,
// clears the error history and the integral and answers with a run command
// carrying base_duty; a stop clears the same state and answers with brake and
// zero duty. A sample while running answers with set duty and the controller
// output (kp*e + ki*sum + kd*(e - previous e)) >> 8, saturated to 16 bits
// signed, where e = target - |measured| and sum is clamped to
// +/- integral_limit. A sample while stopped gives no result beat. One command
// beat is taken every clock cycle while the result side keeps up; a result beat
// passes through the command register and then the result register. A result
// held by the receiver stalls the command register, and the command input
// behind it, once that register holds a command that owes a result; a sample
// while stopped still passes. The rate is set by the combinational datapath
// between those two registers: error, clamp, two 16x18 multiplies, one 16x16
// multiply and the final sum. Gains and limits sit in an APB register file at
// byte addresses 0, 4, 8, 12 and 16.
module motor_speed_pid_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] target_speed,
	input  logic signed [15:0] measured_speed,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  motor_command,
	output logic signed [15:0] duty,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mspc_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

	// configuration registers
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [LIMIT_W-1:0]       int_limit_q;
	logic [DUTY_W-1:0]        base_duty_q;

	// loop state
	logic                     running_q;
	logic [SPEED_W-1:0]       target_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [SUM_W-1:0]  sum_q;

	// command register
	logic                     valid_s1;
	logic [1:0]               op_s1;
	logic [SPEED_W-1:0]       target_s1;
	logic signed [15:0]       meas_s1;

	// result register
	logic                     out_valid_q;
	logic [1:0]               cmd_q;
	logic signed [DUTY_W-1:0] duty_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= GAIN_W'(256);
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			int_limit_q <= LIMIT_W'(300);
			base_duty_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GAIN_P:    gain_p_q    <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:    gain_i_q    <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:    gain_d_q    <= pwdata[GAIN_W-1:0];
				REG_INT_LIMIT: int_limit_q <= pwdata[LIMIT_W-1:0];
				REG_BASE_DUTY: base_duty_q <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GAIN_P:    prdata = PDATA_W'(unsigned'(gain_p_q));
			REG_GAIN_I:    prdata = PDATA_W'(unsigned'(gain_i_q));
			REG_GAIN_D:    prdata = PDATA_W'(unsigned'(gain_d_q));
			REG_INT_LIMIT: prdata = PDATA_W'(int_limit_q);
			REG_BASE_DUTY: prdata = PDATA_W'(base_duty_q);
			default:       prdata = '0;
		endcase
	end

	// ---- handshake ----
	op_t  op;
	logic has_result;
	logic go_s1;

	assign op         = op_t'(op_s1);
	// a sample while stopped leaves nothing to deliver, so it never waits
	assign has_result = (op != OP_SAMPLE) || running_q;
	assign go_s1      = valid_s1 && (!has_result || !out_valid_q || result_ready);
	assign cmd_ready  = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			op_s1     <= operation;
			target_s1 <= target_speed;
			meas_s1   <= measured_speed;
		end
	end

	// ---- pid datapath ----
	logic [15:0]              mag;
	logic signed [ERR_W-1:0]  err;
	logic signed [ERR_W-1:0]  derr;
	logic signed [ERR_W-1:0]  sum_raw;
	logic signed [ERR_W-1:0]  lim;
	logic signed [SUM_W-1:0]  sum_cl;
	logic signed [33:0]       prod_p, prod_i, prod_d;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_sh;
	logic signed [DUTY_W-1:0] pid_out;

	always_comb begin
		// magnitude; the most negative reading maps to 32768
		mag     = meas_s1[15] ? (~meas_s1 + 16'd1) : meas_s1;
		err     = signed'({2'b00, target_q}) - signed'({2'b00, mag});
		derr    = err - err_q;
		sum_raw = ERR_W'(sum_q) + err;
		lim     = signed'(ERR_W'(int_limit_q));
		if (sum_raw > lim) begin
			sum_cl = lim[SUM_W-1:0];
		end else if (sum_raw < -lim) begin
			sum_cl = SUM_W'(-lim);
		end else begin
			sum_cl = sum_raw[SUM_W-1:0];
		end
		prod_p  = gain_p_q * err;
		prod_i  = gain_i_q * sum_cl;
		prod_d  = gain_d_q * derr;
		acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
		// arithmetic shift floors toward minus infinity
		acc_sh  = acc >>> GAIN_FRAC_BITS;
		if (acc_sh > SAT_HI) begin
			pid_out = 16'sh7fff;
		end else if (acc_sh < SAT_LO) begin
			pid_out = -16'sh8000;
		end else begin
			pid_out = acc_sh[DUTY_W-1:0];
		end
	end

	// ---- state update ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			target_q  <= '0;
			err_q     <= '0;
			sum_q     <= '0;
		end else if (go_s1) begin
			unique case (op)
				OP_START_FWD, OP_START_REV: begin
					running_q <= 1'b1;
					target_q  <= target_s1;
					err_q     <= '0;
					sum_q     <= '0;
				end
				OP_STOP: begin
					running_q <= 1'b0;
					err_q     <= '0;
					sum_q     <= '0;
				end
				default: begin
					if (running_q) begin
						err_q <= err;
						sum_q <= sum_cl;
					end
				end
			endcase
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && has_result) begin
			unique case (op)
				OP_START_FWD: begin
					cmd_q  <= CMD_RUN_FWD;
					duty_q <= base_duty_q;
				end
				OP_START_REV: begin
					cmd_q  <= CMD_RUN_REV;
					duty_q <= base_duty_q;
				end
				OP_STOP: begin
					cmd_q  <= CMD_BRAKE;
					duty_q <= '0;
				end
				default: begin
					cmd_q  <= CMD_SET_DUTY;
					duty_q <= pid_out;
				end
			endcase
		end
	end

	assign result_valid  = out_valid_q;
	assign motor_command = cmd_q;
	assign duty          = duty_q;

endmodule

### rtl/mspc_checker.sv
`include "motor_speed_pid_controller_core_defines.svh"

module mspc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  motor_command,
	input logic [15:0] duty
);
	import mspc_pkg::*;

	// a stalled result beat holds
	`MSPC_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(motor_command) && $stable(duty), "stalled result changed")

	// brake always carries zero duty
	`MSPC_ASSERT_IMP(a_brake_zero, result_valid && (motor_command == CMD_BRAKE), duty == 16'd0, "brake with nonzero duty")

	// commands back up only behind a stalled result
	`MSPC_ASSERT_IMP(a_ready_stall, !cmd_ready, result_valid && !result_ready, "command stall without result backpressure")

endmodule

bind motor_speed_pid_controller_core mspc_checker u_mspc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_ready     (cmd_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.motor_command (motor_command),
	.duty          (duty)
);

### dv/tb_motor_speed_pid_controller_core.sv
`timescale 1ns / 1ps

module tb_motor_speed_pid_controller_core;
	import mspc_pkg::*;

	// run limits, in clock cycles
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_LIMIT = 5000;
	// extra settle time once nothing more is owed
	localparam int SETTLE_CYCLES = 4;
	// length of the long result stall that fills the block
	localparam int HOLD_CYCLES = 400;

	// one expected result beat
	typedef struct {
		cmd_t               command;
		logic signed [15:0] duty_value;
	} drive_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	logic [1:0]  operation;
	logic [15:0] target_speed;
	logic signed [15:0] measured_speed;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  motor_command;
	logic signed [15:0] duty;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the register file, as last written
	logic signed [15:0] kp;
	logic signed [15:0] ki;
	logic signed [15:0] kd;
	logic [14:0]        sum_limit;
	logic [15:0]        start_duty;

	// shadow of the loop state
	logic               loop_running;
	logic [15:0]        loop_target;
	logic signed [17:0] last_error;
	logic signed [15:0] error_integral;

	// result beats still owed by the block, oldest first
	drive_beat_t drive_queue[$];

	int error_count = 0;
	int cycle_count = 0;

	// sender burst shaping
	int burst_left = 0;
	bit steady_sender = 1'b0;

	// receiver stall shaping
	int stall_mode = 0;
	int stall_span = 0;
	int hold_left = 0;

	motor_speed_pid_controller_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.operation      (operation),
		.target_speed   (target_speed),
		.measured_speed (measured_speed),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.motor_command  (motor_command),
		.duty           (duty),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: a stuck handshake ends the run here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// apply one command to the shadow loop and queue the beat it owes
	task automatic compute_drive(input op_t op, input logic [15:0] tgt,
			input logic signed [15:0] meas);
		drive_beat_t beat;
		int mag;
		int err;
		int clamped_sum;
		longint acc;
		longint y;
		case (op)
			OP_START_FWD, OP_START_REV: begin
				loop_target = tgt;
				last_error = '0;
				error_integral = '0;
				loop_running = 1'b1;
				beat.command = (op == OP_START_FWD) ? CMD_RUN_FWD : CMD_RUN_REV;
				beat.duty_value = start_duty;
				drive_queue.push_back(beat);
			end
			OP_STOP: begin
				last_error = '0;
				error_integral = '0;
				loop_running = 1'b0;
				beat.command = CMD_BRAKE;
				beat.duty_value = '0;
				drive_queue.push_back(beat);
			end
			default: begin
				// a sample while stopped leaves everything alone
				if (loop_running) begin
					mag = int'(meas);
					if (mag < 0)
						mag = -mag;
					err = int'(loop_target) - mag;
					clamped_sum = error_integral + err;
					if (clamped_sum > int'(sum_limit))
						clamped_sum = int'(sum_limit);
					if (clamped_sum < -int'(sum_limit))
						clamped_sum = -int'(sum_limit);
					acc = longint'(kp) * err + longint'(ki) * clamped_sum
						+ longint'(kd) * (err - last_error);
					// arithmetic shift floors, then saturate to the duty width
					y = acc >>> GAIN_FRAC_BITS;
					if (y > 32767)
						y = 32767;
					if (y < -32768)
						y = -32768;
					last_error = 18'(err);
					error_integral = 16'(clamped_sum);
					beat.command = CMD_SET_DUTY;
					beat.duty_value = y[15:0];
					drive_queue.push_back(beat);
				end
			end
		endcase
	endtask

	// offer one command beat; called and returns just after a rising edge
	task automatic send_command(input op_t op, input logic [15:0] tgt,
			input logic signed [15:0] meas);
		if (burst_left == 0) begin
			// end of a burst: drop valid for a random gap unless the sender is steady
			if (!steady_sender) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		operation <= op;
		target_speed <= tgt;
		measured_speed <= meas;
		do
			@(posedge clk);
		while (!cmd_ready);
		compute_drive(op, tgt, meas);
	endtask

	// stop offering and wait until the block has nothing left to say
	task automatic settle_idle();
		cmd_valid <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write followed by a read back of the same register
	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_INT_LIMIT) ? 32'h0000_7fff : 32'h0000_ffff;
		// setup then access; the write lands on the access edge
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_GAIN_P:    kp = value[15:0];
			REG_GAIN_I:    ki = value[15:0];
			REG_GAIN_D:    kd = value[15:0];
			REG_INT_LIMIT: sum_limit = value[14:0];
			REG_BASE_DUTY: start_duty = value[15:0];
			default: ;
		endcase
		// back to back read, psel stays high
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (value & mask))
			report_mismatch($sformatf("register %0d read back %h, wrote %h",
				idx, prdata & mask, value & mask));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(input logic [15:0] p, input logic [15:0] i,
			input logic [15:0] d, input logic [14:0] lim, input logic [15:0] base);
		write_register(REG_GAIN_P, {16'h0, p});
		write_register(REG_GAIN_I, {16'h0, i});
		write_register(REG_GAIN_D, {16'h0, d});
		write_register(REG_INT_LIMIT, {17'h0, lim});
		write_register(REG_BASE_DUTY, {16'h0, base});
	endtask

	// mostly modest gains so the output does not always saturate
	function automatic logic [15:0] random_gain();
		int g;
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		g = $urandom_range(0, 1024);
		return 16'(g - 512);
	endfunction

	function automatic logic [14:0] random_limit();
		case ($urandom_range(0, 4))
			0: return 15'd0;
			1: return 15'h7fff;
			2: return 15'($urandom);
			default: return 15'($urandom_range(1, 2000));
		endcase
	endfunction

	function automatic logic [15:0] pick_target();
		if ($urandom_range(0, 9) < 7)
			return 16'($urandom_range(0, 3000));
		return 16'($urandom);
	endfunction

	// speed close to the target, either sign, or sometimes anything at all
	function automatic logic signed [15:0] pick_measurement(input logic [15:0] tgt);
		int m;
		int d;
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		d = $urandom_range(0, 400);
		m = int'(tgt) + d - 200;
		if (m < 0)
			m = 0;
		if (m > 32767)
			m = 32767;
		return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
	endfunction

	// start, a run of samples, maybe a stop; some pure noise in between
	task automatic run_sequences(input int item_total);
		int sent;
		logic [15:0] tgt;
		sent = 0;
		while (sent < item_total) begin
			if ($urandom_range(0, 9) < 8) begin
				tgt = pick_target();
				send_command(($urandom_range(0, 1) != 0) ? OP_START_FWD : OP_START_REV,
					tgt, 16'($urandom));
				sent++;
				repeat ($urandom_range(1, 30)) begin
					send_command(OP_SAMPLE, 16'($urandom), pick_measurement(tgt));
					sent++;
				end
				if ($urandom_range(0, 1) != 0) begin
					send_command(OP_STOP, 16'($urandom), 16'($urandom));
					sent++;
				end
			end else begin
				send_command(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
				sent++;
			end
		end
	endtask

	// settings out of reset: kp 1.0, no integral or derivative, base duty 0
	task automatic test_default_settings();
		// sample before any start gives nothing
		send_command(OP_SAMPLE, 16'd500, 16'sd400);
		send_command(OP_START_FWD, 16'd1000, 16'sd0);
		send_command(OP_SAMPLE, 16'd0, 16'sd900);
		send_command(OP_SAMPLE, 16'd0, -16'sd1200);
		send_command(OP_STOP, 16'd0, 16'sd0);
		settle_idle();
	endtask

	// extreme gains, limits and speeds, repeated start and double stop
	task automatic test_field_extremes();
		apply_settings(16'h7fff, 16'h8000, 16'h7fff, 15'h7fff, 16'hffff);
		send_command(OP_START_REV, 16'hffff, 16'sd0);
		// most negative reading has magnitude 32768
		send_command(OP_SAMPLE, 16'h0000, 16'sh8000);
		send_command(OP_SAMPLE, 16'hffff, 16'sh7fff);
		send_command(OP_SAMPLE, 16'h0000, 16'sd0);
		// restart while running reloads the target and clears history
		send_command(OP_START_FWD, 16'h0000, 16'sh7fff);
		send_command(OP_SAMPLE, 16'h0000, 16'sh8000);
		send_command(OP_STOP, 16'hffff, 16'shffff);
		// stop while already stopped still brakes
		send_command(OP_STOP, 16'h0000, 16'sd0);
		send_command(OP_SAMPLE, 16'h1234, 16'sd77);
		settle_idle();
		apply_settings(16'h8000, 16'h7fff, 16'h8000, 15'h0000, 16'h8000);
		send_command(OP_START_FWD, 16'h0000, 16'sd0);
		send_command(OP_SAMPLE, 16'h0000, 16'sd0);
		send_command(OP_SAMPLE, 16'h0000, 16'sd1);
		send_command(OP_START_REV, 16'd40000, 16'sd0);
		send_command(OP_SAMPLE, 16'h0000, 16'sd12345);
		send_command(OP_STOP, 16'h0000, 16'sd0);
		settle_idle();
	endtask

	// receiver holds off for a long stretch while commands keep coming
	task automatic test_output_backpressure();
		apply_settings(16'd256, 16'd32, 16'd64, 15'd500, 16'd1234);
		steady_sender = 1'b1;
		hold_left <= HOLD_CYCLES;
		send_command(OP_START_FWD, 16'd1500, 16'sd0);
		repeat (60)
			send_command(OP_SAMPLE, 16'($urandom), pick_measurement(16'd1500));
		send_command(OP_STOP, 16'd0, 16'sd0);
		steady_sender = 1'b0;
		settle_idle();
	endtask

	// random sequences across several register settings, extremes first
	task automatic test_random_settings();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: apply_settings(16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 16'hffff);
				1: apply_settings(16'h8000, 16'h8000, 16'h8000, 15'h0000, 16'h0000);
				default: apply_settings(random_gain(), random_gain(), random_gain(),
					random_limit(), 16'($urandom));
			endcase
			run_sequences(200);
			settle_idle();
		end
	endtask

	// receiver: stall pattern switches between random modes, each held for a random span
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(10, 80);
		end
		stall_span--;
		if (hold_left != 0)
			result_ready <= 1'b0;
		else begin
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= ($urandom_range(0, 3) == 0);
				default: result_ready <= (cycle_count % 3 != 0);
			endcase
		end
	end

	// long hold-off countdown
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result check: each beat against the oldest expectation
	always @(posedge clk) begin
		drive_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (drive_queue.size() == 0)
				report_mismatch($sformatf("unexpected beat: cmd %0d duty %0d",
					motor_command, duty));
			else begin
				want = drive_queue.pop_front();
				if (motor_command !== want.command)
					report_mismatch($sformatf("motor_command %0d, expected %0d",
						motor_command, want.command));
				if (duty !== want.duty_value)
					report_mismatch($sformatf("duty %0d, expected %0d (cmd %0d)",
						duty, want.duty_value, want.command));
			end
		end
	end

	initial begin
		int drain_cycles;
		// every input known from time zero
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		operation <= OP_SAMPLE;
		target_speed <= '0;
		measured_speed <= '0;
		result_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		// shadow state matches reset
		kp = 16'sd256;
		ki = '0;
		kd = '0;
		sum_limit = 15'd300;
		start_duty = '0;
		loop_running = 1'b0;
		loop_target = '0;
		last_error = '0;
		error_integral = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_field_extremes();
		test_output_backpressure();
		test_random_settings();

		// drain whatever is still owed, then give late beats a chance
		cmd_valid <= 1'b0;
		drain_cycles = 0;
		while (drive_queue.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (8) @(posedge clk);
		if (drive_queue.size() != 0)
			report_mismatch($sformatf("%0d result beats never arrived",
				drive_queue.size()));

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
